FILE: src/usbes_pkg.sv
package usbes_pkg;

  localparam int ENDPOINT_PAIRS_DEF   = 4;
  localparam int MAX_PACKET_BYTES_DEF = 64;
  localparam int LENGTH_BITS_DEF      = 16;

  typedef enum logic [2:0] {
    OP_OPEN      = 3'd0,
    OP_ARM_IN    = 3'd1,
    OP_ARM_OUT   = 3'd2,
    OP_OUT_PKT   = 3'd3,
    OP_IN_ACK    = 3'd4,
    OP_BUS_RESET = 3'd5,
    OP_SETUP     = 3'd6,
    OP_SET_ADDR  = 3'd7
  } op_t;

  localparam logic       ST_OK       = 1'b0;
  localparam logic       ST_DISABLED = 1'b1;

  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_OUT_DONE = 2'd1;
  localparam logic [1:0] EV_IN_DONE  = 2'd2;

  typedef struct packed {
    op_t         op;
    logic [1:0]  ep_index;
    logic        is_in;
    logic [6:0]  max_packet;
    logic [15:0] length;
    logic [3:0]  packet_toggle;
    logic [6:0]  rx_bytes;
    logic [6:0]  new_address;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [1:0]  event_res;
    logic [1:0]  event_ep;
    logic [15:0] actual_len;
    logic        payload_valid;
    logic [6:0]  payload_len;
    logic [15:0] buffer_offset;
    logic        set_data1;
    logic [6:0]  device_address;
  } out_item_t;

  typedef struct packed {
    logic [6:0] active;
    logic [6:0] pending;
    logic       pending_flag;
  } addr_state_t;

  typedef struct packed {
    logic wr_en;
    logic clr_tog_rest;
    logic clr_tog_ep0;
  } exec_ctl_t;

  // two max packet sizes, two enables, six length words, one toggle code
  function automatic int entry_width(input int lb);
    return 2 * 7 + 2 + 6 * lb + 4;
  endfunction

endpackage

FILE: src/usb_endpoint_transfer_sequencer.sv
// timing: the request and the endpoint ram read are registered at the accepting edge;
//   the result is computed while busy and registered into the output register
//   no transaction is accepted while busy: the endpoint ram read, then the read-modify-write
// reset: synchronous, active low; clears the control state, the address
//   registers and the per-endpoint valid bits, so every endpoint reads as zero
// the receiver cannot stall; each result is shown for exactly one cycle
module usb_endpoint_transfer_sequencer #(
  parameter int ENDPOINT_PAIRS   = usbes_pkg::ENDPOINT_PAIRS_DEF,
  parameter int MAX_PACKET_BYTES = usbes_pkg::MAX_PACKET_BYTES_DEF,
  parameter int LENGTH_BITS      = usbes_pkg::LENGTH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  usbes_pkg::in_item_t  in_data,
  output logic                 out_valid,
  output usbes_pkg::out_item_t out_data
);

  localparam int IDX_W = (ENDPOINT_PAIRS > 1) ? $clog2(ENDPOINT_PAIRS) : 1;
  localparam int EW    = usbes_pkg::entry_width(LENGTH_BITS);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                 state_r, state_nxt;
  usbes_pkg::in_item_t    item_r;
  usbes_pkg::addr_state_t addr_r;
  usbes_pkg::addr_state_t addr_nxt;
  usbes_pkg::out_item_t   result;
  usbes_pkg::out_item_t   out_data_r;
  usbes_pkg::exec_ctl_t   ctl;
  logic                   out_valid_r;
  logic [ENDPOINT_PAIRS-1:0] ent_valid_r;
  logic [ENDPOINT_PAIRS-1:0] tog_valid_r;
  logic                   accept;
  logic                   ep_ok;
  logic [IDX_W-1:0]       rd_idx;
  logic [IDX_W-1:0]       idx;
  logic [EW-1:0]          rd_data;
  logic [EW-1:0]          wr_data;
  logic                   ent_v;
  logic                   tog_v;

  assign busy   = (state_r == S_EXEC);
  assign accept = start && !busy;
  assign rd_idx = IDX_W'(in_data.ep_index);
  assign idx    = IDX_W'(item_r.ep_index);
  assign ep_ok  = 32'(item_r.ep_index) < ENDPOINT_PAIRS;
  assign ent_v  = ep_ok && ent_valid_r[idx];
  assign tog_v  = ep_ok && tog_valid_r[idx];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  usbes_ep_ram #(
    .DEPTH (ENDPOINT_PAIRS),
    .WIDTH (EW),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_idx),
    .rd_data (rd_data),
    .wr_en   (busy && ctl.wr_en),
    .wr_addr (idx),
    .wr_data (wr_data)
  );

  usbes_exec #(
    .ENDPOINT_PAIRS   (ENDPOINT_PAIRS),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
    .LENGTH_BITS      (LENGTH_BITS),
    .EW               (EW)
  ) u_exec (
    .item      (item_r),
    .rd_data   (rd_data),
    .ent_valid (ent_v),
    .tog_valid (tog_v),
    .addr_cur  (addr_r),
    .wr_data   (wr_data),
    .ctl       (ctl),
    .result    (result),
    .addr_nxt  (addr_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      addr_r      <= '0;
      ent_valid_r <= '0;
      tog_valid_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= busy;
      if (busy) begin
        addr_r <= addr_nxt;
        if (ctl.wr_en) begin
          ent_valid_r[idx] <= 1'b1;
          tog_valid_r[idx] <= 1'b1;
        end
        if (ctl.clr_tog_rest) begin
          for (int i = 1; i < ENDPOINT_PAIRS; i++) begin
            tog_valid_r[i] <= 1'b0;
          end
        end
        if (ctl.clr_tog_ep0) begin
          tog_valid_r[0] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (busy) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start execution");

  a_exec_one: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("execution did not produce a result in one cycle");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without execution");

  a_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.payload_valid) |->
      (out_data.payload_len == 7'd0 && out_data.buffer_offset == 16'd0))
    else $error("payload fields set without payload valid");

endmodule

FILE: src/usbes_ep_ram.sv
module usbes_ep_ram #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8,
  parameter int AW    = 2
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/usbes_exec.sv
module usbes_exec #(
  parameter int ENDPOINT_PAIRS   = usbes_pkg::ENDPOINT_PAIRS_DEF,
  parameter int MAX_PACKET_BYTES = usbes_pkg::MAX_PACKET_BYTES_DEF,
  parameter int LENGTH_BITS      = usbes_pkg::LENGTH_BITS_DEF,
  parameter int EW               = usbes_pkg::entry_width(LENGTH_BITS)
) (
  input  usbes_pkg::in_item_t    item,
  input  logic [EW-1:0]          rd_data,
  input  logic                   ent_valid,
  input  logic                   tog_valid,
  input  usbes_pkg::addr_state_t addr_cur,
  output logic [EW-1:0]          wr_data,
  output usbes_pkg::exec_ctl_t   ctl,
  output usbes_pkg::out_item_t   result,
  output usbes_pkg::addr_state_t addr_nxt
);

  localparam int LB = LENGTH_BITS;
  localparam logic [6:0] MP_CAP = 7'(MAX_PACKET_BYTES);

  typedef struct packed {
    logic [6:0]    in_mp;
    logic [6:0]    out_mp;
    logic          in_en;
    logic          out_en;
    logic [LB-1:0] in_rem;
    logic [LB-1:0] in_off;
    logic [LB-1:0] in_act;
    logic [LB-1:0] out_rem;
    logic [LB-1:0] out_off;
    logic [LB-1:0] out_act;
    logic [3:0]    toggle;
  } entry_t;

  function automatic logic [LB-1:0] sat_add(input logic [LB-1:0] a, input logic [LB-1:0] b);
    logic [LB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LB] ? {LB{1'b1}} : s[LB-1:0];
  endfunction

  function automatic logic [LB-1:0] sat_sub(input logic [LB-1:0] a, input logic [LB-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  function automatic logic [6:0] min_mp(input logic [LB-1:0] a, input logic [6:0] mp);
    return (a < LB'(mp)) ? a[6:0] : mp;
  endfunction

  entry_t        e;
  entry_t        n;
  logic          ep_op;
  logic          ep_ok;
  logic [6:0]    mp_clamped;
  logic [LB-1:0] len;
  logic [LB-1:0] recv;

  always_comb begin
    e = ent_valid ? entry_t'(rd_data) : '0;
    if (!tog_valid) begin
      e.toggle = '0;
    end
    n          = e;
    ep_op      = (item.op != usbes_pkg::OP_BUS_RESET) && (item.op != usbes_pkg::OP_SETUP) &&
                 (item.op != usbes_pkg::OP_SET_ADDR);
    ep_ok      = 32'(item.ep_index) < ENDPOINT_PAIRS;
    mp_clamped = (item.max_packet > MP_CAP) ? MP_CAP : item.max_packet;
    len        = LB'(item.length);
    recv       = LB'(item.rx_bytes);
    addr_nxt   = addr_cur;
    ctl        = '0;
    result     = '0;
    result.status    = usbes_pkg::ST_OK;
    result.event_res = usbes_pkg::EV_NONE;
    result.event_ep  = ep_op ? item.ep_index : 2'd0;

    if (ep_op && !ep_ok) begin
      result.status = usbes_pkg::ST_DISABLED;
    end else begin
      unique case (item.op)
        usbes_pkg::OP_OPEN: begin
          if (item.is_in) begin
            n.in_mp = mp_clamped;
            n.in_en = 1'b1;
          end else begin
            n.out_mp = mp_clamped;
            n.out_en = 1'b1;
          end
          ctl.wr_en = 1'b1;
        end
        usbes_pkg::OP_ARM_IN: begin
          if (!e.in_en) begin
            result.status = usbes_pkg::ST_DISABLED;
          end else begin
            n.in_rem  = len;
            n.in_off  = '0;
            n.in_act  = '0;
            ctl.wr_en = 1'b1;
            result.payload_valid = 1'b1;
            result.payload_len   = min_mp(len, e.in_mp);
            result.set_data1     = (item.ep_index == 2'd0);
          end
        end
        usbes_pkg::OP_ARM_OUT: begin
          if (!e.out_en) begin
            result.status = usbes_pkg::ST_DISABLED;
          end else begin
            n.out_rem = len;
            n.out_off = '0;
            n.out_act = '0;
            ctl.wr_en = 1'b1;
            result.payload_valid = 1'b1;
            result.payload_len   = min_mp(len, e.out_mp);
          end
        end
        usbes_pkg::OP_OUT_PKT: begin
          if (item.packet_toggle == e.toggle) begin
            // repeated packet, re-arm for a full packet
            result.payload_valid = 1'b1;
            result.payload_len   = e.out_mp;
            result.buffer_offset = 16'(e.out_off);
          end else begin
            n.out_off = sat_add(e.out_off, recv);
            n.out_rem = sat_sub(e.out_rem, recv);
            n.out_act = sat_add(e.out_act, recv);
            n.toggle  = item.packet_toggle;
            ctl.wr_en = 1'b1;
            if ((item.rx_bytes < e.out_mp) || (n.out_rem == '0)) begin
              result.event_res = usbes_pkg::EV_OUT_DONE;
            end else begin
              result.payload_valid = 1'b1;
              result.payload_len   = min_mp(n.out_rem, e.out_mp);
              result.buffer_offset = 16'(n.out_off);
            end
          end
          result.actual_len = 16'(n.out_act);
        end
        usbes_pkg::OP_IN_ACK: begin
          if ((item.ep_index == 2'd0) && addr_cur.pending_flag) begin
            addr_nxt.active       = addr_cur.pending;
            addr_nxt.pending_flag = 1'b0;
          end
          if (e.in_rem > LB'(e.in_mp)) begin
            n.in_off = sat_add(e.in_off, LB'(e.in_mp));
            n.in_rem = e.in_rem - LB'(e.in_mp);
            n.in_act = sat_add(e.in_act, LB'(e.in_mp));
            result.payload_valid = 1'b1;
            result.payload_len   = min_mp(n.in_rem, e.in_mp);
            result.buffer_offset = 16'(n.in_off);
          end else begin
            n.in_act = sat_add(e.in_act, e.in_rem);
            n.in_rem = '0;
            result.event_res = usbes_pkg::EV_IN_DONE;
          end
          ctl.wr_en = 1'b1;
          result.actual_len = 16'(n.in_act);
        end
        usbes_pkg::OP_BUS_RESET: begin
          ctl.clr_tog_rest = 1'b1;
          addr_nxt.active  = '0;
          addr_nxt.pending = '0;
        end
        usbes_pkg::OP_SETUP: begin
          ctl.clr_tog_ep0 = 1'b1;
        end
        usbes_pkg::OP_SET_ADDR: begin
          if ((addr_cur.active == 7'd0) && (item.new_address != 7'd0)) begin
            addr_nxt.pending      = item.new_address;
            addr_nxt.pending_flag = 1'b1;
          end
        end
        default: begin
          ctl = '0;
        end
      endcase
    end

    result.device_address = addr_nxt.active;
    wr_data = n;
  end

endmodule
